[hw/rtl/integer_to_text_converter_core_macros.svh]
// assertion macros for the converter checker
`ifndef INTEGER_TO_TEXT_CONVERTER_CORE_MACROS_SVH
`define INTEGER_TO_TEXT_CONVERTER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define I2T_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define I2T_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/i2t_pkg.sv]
// shared constants, types and state codes of the integer to text converter
package i2t_pkg;

  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned IN_VALUE_W  = 64;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned MINW_W      = 5;
  localparam int unsigned CHAR_W      = 7;

  localparam int unsigned HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int unsigned PAD_WIDTH  = HEX_DIGITS * 4;
  localparam int unsigned CONV_STEPS = PAD_WIDTH / 4;
  localparam int unsigned STEP_W     = $clog2(CONV_STEPS);
  localparam int unsigned DEC_DIGITS = 20;
  localparam int unsigned IDX_W      = $clog2(DEC_DIGITS);
  localparam int unsigned CNT_W      = $clog2(DEC_DIGITS + 1);

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [CHAR_W-1:0] CHAR_MINUS    = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_HEX_BASE = 7'd87;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_UDEC = 2'd0,
    FUNC_SDEC = 2'd1,
    FUNC_HEX  = 2'd2,
    FUNC_RSVD = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONV,
    BK_COUNT,
    BK_SIGN,
    BK_EMIT
  } back_state_e;

  // one classified job handed from the front to the back
  typedef struct packed {
    logic                   is_hex;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
    logic [CNT_W-1:0]       width;
  } job_t;

endpackage

[hw/rtl/i2t_if.sv]
// valid/ready channel interfaces for request and character words
interface i2t_in_if;
  import i2t_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [IN_VALUE_W-1:0] value;
  logic [MINW_W-1:0]     min_width;

  modport source (output valid, output func, output value, output min_width, input ready);
  modport sink   (input valid, input func, input value, input min_width, output ready);
endinterface

interface i2t_out_if;
  import i2t_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

[hw/rtl/integer_to_text_converter_core.sv]
// integer to text converter: front classifier, job queue and digit back end
// decimal values pass through the shift-and-add-3 unit, 4 bits per cycle over 64 bits
// the 2-entry queue lets up to two more request words in while one is converted
// reset: asynchronous active low, queue empty, back end idle, no output word
module integer_to_text_converter_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  i2t_in_if.sink    in_i,
  i2t_out_if.source out_o
);
  import i2t_pkg::*;

  // front to queue
  job_t push_job;
  logic push;
  logic full;

  // queue to back
  job_t pop_job;
  logic pop;
  logic empty;

  // front: masks the value, picks hex or decimal, negates signed negatives,
  // clamps the hex width to the nybble count
  i2t_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  // short queue so the request side keeps moving while the back end works
  i2t_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (pop_job),
    .empty_o (empty)
  );

  // back: binary to bcd with the shift-and-add-3 unit for decimal, direct nybble load for hex,
  // then leading digit count and one character per cycle into the output register while it is free
  i2t_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (pop_job),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

[hw/rtl/i2t_front.sv]
// front end: takes request words and classifies them into jobs
module i2t_front (
  i2t_in_if.sink         in_i,
  input  logic           full_i,
  output logic           push_o,
  output i2t_pkg::job_t  job_o
);
  import i2t_pkg::*;

  logic [VALUE_WIDTH-1:0] val;
  logic                   is_hex;
  logic                   neg;

  assign val    = in_i.value[VALUE_WIDTH-1:0];
  assign is_hex = (in_i.func == FUNC_HEX) || (in_i.func == FUNC_RSVD);
  assign neg    = (in_i.func == FUNC_SDEC) && val[VALUE_WIDTH-1];

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    job_o.is_hex = is_hex;
    job_o.neg    = neg;
    // two's complement magnitude, the most negative value maps onto itself
    job_o.mag    = neg ? (~val + 1'b1) : val;
    if (!is_hex) begin
      job_o.width = '0;
    end else if (in_i.min_width > MINW_W'(HEX_DIGITS)) begin
      job_o.width = CNT_W'(HEX_DIGITS);
    end else begin
      job_o.width = CNT_W'(in_i.min_width);
    end
  end

endmodule

[hw/rtl/i2t_queue.sv]
// two-entry job queue between front and back
module i2t_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  i2t_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output i2t_pkg::job_t job_o,
  output logic          empty_o
);
  import i2t_pkg::*;

  job_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_W:0]   count_q;

  assign full_o  = (count_q == (Q_PTR_W + 1)'(Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

[hw/rtl/i2t_back.sv]
// back end: digit extraction and character emission with an output register
module i2t_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  i2t_pkg::job_t job_i,
  input  logic          empty_i,
  output logic          pop_o,
  i2t_out_if.source     out_o
);
  import i2t_pkg::*;

  typedef logic [DEC_DIGITS-1:0][3:0] digits_t;

  // four shift-and-add-3 steps, one per incoming binary bit
  function automatic digits_t dabble4(digits_t bcd, logic [3:0] bits);
    digits_t                   b;
    logic [DEC_DIGITS*4-1:0]   flat;
    b = bcd;
    for (int s = 3; s >= 0; s--) begin
      for (int k = 0; k < DEC_DIGITS; k++) begin
        if (b[k] >= 4'd5) begin
          b[k] = b[k] + 4'd3;
        end
      end
      flat = b;
      b    = {flat[DEC_DIGITS*4-2:0], bits[s]};
    end
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(logic [3:0] d);
    if (d > 4'd9) begin
      return CHAR_W'(d) + CHAR_HEX_BASE;
    end
    return CHAR_W'(d) + CHAR_ZERO;
  endfunction

  back_state_e            state_q, state_d;
  digits_t                digit_q, digit_d;
  logic [PAD_WIDTH-1:0]   shreg_q, shreg_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic                   neg_q, neg_d;
  logic [CNT_W-1:0]       width_q, width_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   out_valid_q;
  logic [CHAR_W-1:0]      char_q;
  logic                   last_q;

  logic                   slot_free;
  logic                   load;
  logic [CHAR_W-1:0]      load_char;
  logic                   load_last;
  logic [PAD_WIDTH-1:0]   pad_mag;
  digits_t                hex_dig;
  logic [CNT_W-1:0]       sig;
  logic [CNT_W-1:0]       n_chars;

  assign slot_free = !out_valid_q || out_o.ready;
  assign pad_mag   = PAD_WIDTH'(job_i.mag);

  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = char_q;
  assign out_o.last      = last_q;

  always_comb begin
    hex_dig = '0;
    for (int k = 0; k < HEX_DIGITS; k++) begin
      hex_dig[k] = pad_mag[k*4 +: 4];
    end
  end

  // position of the top nonzero digit
  always_comb begin
    sig = '0;
    for (int k = 0; k < DEC_DIGITS; k++) begin
      if (digit_q[k] != 4'd0) begin
        sig = CNT_W'(k + 1);
      end
    end
    n_chars = (sig > width_q) ? sig : width_q;
    if (n_chars == '0) begin
      n_chars = CNT_W'(1);
    end
  end

  always_comb begin
    state_d   = state_q;
    digit_d   = digit_q;
    shreg_d   = shreg_q;
    step_d    = step_q;
    neg_d     = neg_q;
    width_d   = width_q;
    idx_d     = idx_q;
    pop_o     = 1'b0;
    load      = 1'b0;
    load_char = CHAR_ZERO;
    load_last = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          neg_d   = job_i.neg;
          width_d = job_i.width;
          shreg_d = pad_mag;
          step_d  = '0;
          if (job_i.is_hex) begin
            digit_d = hex_dig;
            state_d = BK_COUNT;
          end else begin
            digit_d = '0;
            state_d = BK_CONV;
          end
        end
      end
      BK_CONV: begin
        digit_d = dabble4(digit_q, shreg_q[PAD_WIDTH-1 -: 4]);
        shreg_d = shreg_q << 4;
        step_d  = step_q + 1'b1;
        if (step_q == STEP_W'(CONV_STEPS - 1)) begin
          state_d = BK_COUNT;
        end
      end
      BK_COUNT: begin
        idx_d   = IDX_W'(n_chars - 1'b1);
        state_d = neg_q ? BK_SIGN : BK_EMIT;
      end
      BK_SIGN: begin
        if (slot_free) begin
          load      = 1'b1;
          load_char = CHAR_MINUS;
          state_d   = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          load      = 1'b1;
          load_char = digit_char(digit_q[idx_q]);
          load_last = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = BK_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    shreg_q <= shreg_d;
    step_q  <= step_d;
    neg_q   <= neg_d;
    width_q <= width_d;
    idx_q   <= idx_d;
    if (load) begin
      char_q <= load_char;
      last_q <= load_last;
    end
  end

endmodule

[hw/rtl/i2t_chk.sv]
// port-level checker for the converter, bound to the top level
`include "integer_to_text_converter_core_macros.svh"

module i2t_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [i2t_pkg::CHAR_W-1:0] out_char_i,
  input logic                       out_last_i
);
  import i2t_pkg::*;

  logic out_acc;
  logic out_minus;
  logic out_digit;
  logic out_hex;
  logic out_legal;

  assign out_acc   = out_valid_i && out_ready_i;
  assign out_minus = out_valid_i && (out_char_i == CHAR_MINUS);
  assign out_digit = (out_char_i >= CHAR_ZERO) && (out_char_i <= CHAR_ZERO + CHAR_W'(9));
  assign out_hex   = (out_char_i >= CHAR_HEX_BASE + CHAR_W'(10))
                  && (out_char_i <= CHAR_HEX_BASE + CHAR_W'(15));
  assign out_legal = (out_char_i == CHAR_MINUS) || out_digit || out_hex;

  // stalled character word holds
  `I2T_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_char_i) && $stable(out_last_i),
    "stalled character word changed")

  // a sign never ends the text
  `I2T_ASSERT_NOW(a_minus_not_last, out_minus, !out_last_i, "sign marked as last character")

  // a sign is followed by a digit, never by another sign
  `I2T_ASSERT_NEXT(a_minus_once, out_acc && out_minus, !out_minus, "sign repeated")

  // only '-', decimal digits or lower-case hex digits leave the block
  `I2T_ASSERT_NOW(a_char_legal, out_valid_i, out_legal, "illegal character code")

endmodule

bind integer_to_text_converter_core i2t_chk u_i2t_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.char_code),
  .out_last_i  (out_o.last)
);

[verif/testbench.sv]
// self-checking testbench for the integer to text converter core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import i2t_pkg::*;

  // one character word as it leaves the block
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } char_word_t;

  logic clk;
  logic rst_n;

  i2t_in_if  req_if ();
  i2t_out_if char_if ();

  integer_to_text_converter_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (char_if)
  );

  // characters still owed by the block, oldest first
  char_word_t  expected_chars[$];
  int unsigned error_count = 0;

  // idling controls shared by the tests and the two sides
  bit          src_idle  = 1'b1;
  bit          sink_idle = 1'b1;
  int unsigned sink_hold = 0;

  // clock, 4 ns period
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // every input known from time zero, reset held low before release
  initial begin
    rst_n            = 1'b0;
    req_if.valid     = 1'b0;
    req_if.func      = FUNC_UDEC;
    req_if.value     = '0;
    req_if.min_width = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
  end

  // predicted text of one request, appended to the expected characters
  function automatic void predict_text(input func_e op, input logic [IN_VALUE_W-1:0] value,
                                       input logic [MINW_W-1:0] min_width);
    logic [3:0]             digits [DEC_DIGITS];
    logic [VALUE_WIDTH-1:0] mag;
    logic [3:0]             d;
    int unsigned            n;
    int unsigned            sig;
    int unsigned            width_req;
    bit                     neg;
    char_word_t             word;

    mag = value[VALUE_WIDTH-1:0];
    neg = 1'b0;
    n   = 0;
    if (op == FUNC_HEX || op == FUNC_RSVD) begin
      // reserved code acts as hex, oversized width clamps to the nybble count
      width_req = (min_width > HEX_DIGITS) ? HEX_DIGITS : min_width;
      sig = 0;
      for (int i = 0; i < HEX_DIGITS; i++) begin
        if (mag[4*i +: 4] != 4'd0) sig = i + 1;
      end
      n = (sig > width_req) ? sig : width_req;
      // hex zero with no width still gives one digit
      if (n == 0) n = 1;
      for (int i = 0; i < n; i++) digits[i] = mag[4*i +: 4];
    end else begin
      // most negative value negates to itself, which is the right magnitude
      if (op == FUNC_SDEC && mag[VALUE_WIDTH-1]) begin
        neg = 1'b1;
        mag = -mag;
      end
      do begin
        digits[n] = 4'(mag % 10);
        mag       = mag / 10;
        n++;
      end while (mag != 0 && n < DEC_DIGITS);
    end

    if (neg) begin
      word.char_code = CHAR_MINUS;
      word.last      = 1'b0;
      expected_chars.push_back(word);
    end
    for (int i = n - 1; i >= 0; i--) begin
      d = digits[i];
      word.char_code = (d > 9) ? CHAR_HEX_BASE + d : CHAR_ZERO + d;
      word.last      = (i == 0);
      expected_chars.push_back(word);
    end
  endfunction

  // offers one request word, after a random gap when the source idles, predicts it once accepted
  task automatic send_request(input func_e op, input logic [IN_VALUE_W-1:0] value,
                              input logic [MINW_W-1:0] min_width);
    int unsigned gap;

    gap = src_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      @(negedge clk);
      req_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_if.valid     = 1'b1;
    req_if.func      = op;
    req_if.value     = value;
    req_if.min_width = min_width;
    do @(posedge clk); while (!req_if.ready);
    predict_text(op, value, min_width);
  endtask

  // character sink: random stalls per word when idling is on, long hold-off on request, checks each word
  initial begin : char_sink
    int unsigned pause;
    char_word_t  want;

    char_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      pause = sink_idle ? $urandom_range(0, 14) : 0;
      // long hold-off asked by the pressure test, counted here in cycles
      if (sink_hold > 0) begin
        pause     = sink_hold;
        sink_hold = 0;
      end
      if (pause > 0) begin
        @(negedge clk);
        char_if.ready = 1'b0;
        repeat (pause - 1) @(negedge clk);
      end
      @(negedge clk);
      char_if.ready = 1'b1;
      do @(posedge clk); while (!char_if.valid);
      if (expected_chars.size() == 0) begin
        $error("unexpected char word: char_code %0d last %0b",
               char_if.char_code, char_if.last);
        error_count++;
      end else begin
        want = expected_chars.pop_front();
        if (char_if.char_code !== want.char_code) begin
          $error("char_code mismatch: expected %0d actual %0d",
                 want.char_code, char_if.char_code);
          error_count++;
        end
        if (char_if.last !== want.last) begin
          $error("last mismatch: expected %0b actual %0b", want.last, char_if.last);
          error_count++;
        end
      end
    end
  end

  // value classes that reach short, long, boundary and negative texts
  function automatic logic [IN_VALUE_W-1:0] pick_value();
    logic [IN_VALUE_W-1:0] v;
    logic [IN_VALUE_W-1:0] p;
    int unsigned           k;

    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = IN_VALUE_W'($urandom_range(0, 1000));
      2: v = -IN_VALUE_W'($urandom_range(1, 1000));
      3: begin
        // around a power of ten
        p = 64'd1;
        k = $urandom_range(0, 19);
        repeat (k) p = p * 64'd10;
        v = p + IN_VALUE_W'($urandom_range(0, 2)) - 64'd1;
      end
      4: begin
        // around a power of two
        k = $urandom_range(0, 63);
        v = (64'd1 << k) + IN_VALUE_W'($urandom_range(0, 2)) - 64'd1;
      end
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  // decimal extremes: zero, one digit edges, twenty digits, signed corners
  task automatic test_decimal_edges();
    send_request(FUNC_UDEC, 64'd0, 5'd0);
    send_request(FUNC_UDEC, 64'd9, 5'd3);
    send_request(FUNC_UDEC, 64'd10, 5'd0);
    send_request(FUNC_UDEC, 64'd10000000000000000000, 5'd0);
    send_request(FUNC_UDEC, 64'hffff_ffff_ffff_ffff, 5'd31);
    send_request(FUNC_SDEC, 64'd0, 5'd0);
    send_request(FUNC_SDEC, 64'hffff_ffff_ffff_ffff, 5'd0);
    send_request(FUNC_SDEC, 64'h8000_0000_0000_0000, 5'd0);
    send_request(FUNC_SDEC, 64'h7fff_ffff_ffff_ffff, 5'd16);
    send_request(FUNC_SDEC, 64'h8000_0000_0000_0001, 5'd0);
  endtask

  // hex: zero with various widths, clamped widths, full value, reserved code
  task automatic test_hex_edges();
    send_request(FUNC_HEX, 64'd0, 5'd0);
    send_request(FUNC_HEX, 64'd0, 5'd5);
    send_request(FUNC_HEX, 64'd0, 5'd16);
    send_request(FUNC_HEX, 64'd0, 5'd31);
    send_request(FUNC_HEX, 64'hffff_ffff_ffff_ffff, 5'd0);
    send_request(FUNC_HEX, 64'd1, 5'd16);
    send_request(FUNC_HEX, 64'hf000_0000_0000_0000, 5'd17);
    send_request(FUNC_HEX, 64'h0000_0000_00ab_cdef, 5'd2);
    send_request(FUNC_HEX, 64'h0123_4567_89ab_cdef, 5'd10);
    send_request(FUNC_RSVD, 64'h0000_0000_0000_0a5f, 5'd8);
    send_request(FUNC_RSVD, 64'd0, 5'd0);
  endtask

  // random requests in blocks, idling switched per block
  task automatic test_random_requests();
    func_e op;

    for (int blk = 0; blk < 6; blk++) begin
      // one block with no idling on either side, the rest mixed
      src_idle  = (blk != 2) && $urandom_range(0, 3) != 0;
      sink_idle = (blk != 2) && $urandom_range(0, 3) != 0;
      repeat (30) begin
        // reserved code kept rare
        op = ($urandom_range(0, 9) == 0) ? FUNC_RSVD : func_e'($urandom_range(0, 2));
        send_request(op, pick_value(), MINW_W'($urandom_range(0, 31)));
      end
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  // sink holds off while the source keeps offering, so the job queue fills
  task automatic test_output_backpressure();
    src_idle  = 1'b0;
    sink_hold = 400;
    repeat (10) begin
      send_request(func_e'($urandom_range(0, 3)), pick_value(),
                   MINW_W'($urandom_range(0, 31)));
    end
    src_idle = 1'b1;
  endtask

  // test sequence and end of run
  initial begin : test_sequence
    @(posedge rst_n);
    test_decimal_edges();
    test_hex_edges();
    test_random_requests();
    test_output_backpressure();
    @(negedge clk);
    req_if.valid = 1'b0;
    // drain, then allow a full decimal conversion time for strays
    wait (expected_chars.size() == 0);
    repeat (64) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin : run_limit
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/i2t_pkg.sv
hw/rtl/i2t_if.sv
hw/rtl/i2t_front.sv
hw/rtl/i2t_queue.sv
hw/rtl/i2t_back.sv
hw/rtl/integer_to_text_converter_core.sv
hw/rtl/i2t_chk.sv
verif/testbench.sv
